/* design/shadow_brightness_tracker_core_macros.svh */
// Assertion macros for the shadow brightness tracker.
`ifndef SHADOW_BRIGHTNESS_TRACKER_CORE_MACROS_SVH
`define SHADOW_BRIGHTNESS_TRACKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SBT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SBT_ASSERT(lbl, prop, msg)
`define SBT_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* design/sbt_pkg.sv */
// Shared types and constants of the shadow brightness tracker.
package sbt_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int CH_W          = 2;
  localparam int WEIGHT_W      = 17;
  localparam int WFRAC         = 16;
  localparam int PROD_W        = SAMPLE_W + WFRAC;
  localparam int OUT_W         = 8;
  localparam int NUM_W         = SAMPLE_W + OUT_W;
  localparam int CFG_IDX_W     = 1;
  localparam int CHANNELS_DEF  = 3;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'h10000;
  localparam logic [WEIGHT_W-1:0] FAST_RESET  = 17'd45875;
  localparam logic [WEIGHT_W-1:0] SLOW_RESET  = 17'd66;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST = 1'b0,
    CFG_SLOW = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CAL    = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

/* design/sbt_in_if.sv */
// Input channel of the shadow brightness tracker.
interface sbt_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [sbt_pkg::CH_W-1:0]     channel;
  logic [sbt_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output op, output channel, output sample, input ready);
  modport sink (input valid, input op, input channel, input sample, output ready);
endinterface

/* design/sbt_out_if.sv */
// Result channel of the shadow brightness tracker.
interface sbt_out_if;
  logic                      valid;
  logic                      ready;
  logic [sbt_pkg::OUT_W-1:0] brightness;
  logic [sbt_pkg::CH_W-1:0]  out_channel;

  modport source (output valid, output brightness, output out_channel, input ready);
  modport sink (input valid, input brightness, input out_channel, output ready);
endinterface

/* design/sbt_mul.sv */
// Bit-serial blend multiplier: ambient * (1 - w) + sample * w in Q10.16.
module sbt_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sbt_pkg::SAMPLE_W-1:0]  amb_i,
  input  logic [sbt_pkg::SAMPLE_W-1:0]  smp_i,
  input  logic [sbt_pkg::WEIGHT_W-1:0]  w_i,
  output logic                          done_o,
  output logic [sbt_pkg::PROD_W-1:0]    prod_o
);

  localparam int ACC_W = sbt_pkg::PROD_W + 2;
  localparam int CNT_W = $clog2(sbt_pkg::WEIGHT_W + 1);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic [sbt_pkg::SAMPLE_W-1:0]      amb_q, amb_d;
  logic signed [sbt_pkg::SAMPLE_W:0] diff_q, diff_d;
  logic [sbt_pkg::WEIGHT_W-1:0]      w_q, w_d;
  logic signed [ACC_W-1:0]           acc_q, acc_d;
  logic signed [ACC_W-1:0]           sum;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    amb_d  = amb_q;
    diff_d = diff_q;
    w_d    = w_q;
    acc_d  = acc_q;
    if (start_i) begin
      amb_d  = amb_i;
      diff_d = $signed({1'b0, smp_i}) - $signed({1'b0, amb_i});
      w_d    = w_i;
      acc_d  = '0;
      cnt_d  = CNT_W'(sbt_pkg::WEIGHT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = (acc_q <<< 1) + (w_q[sbt_pkg::WEIGHT_W-1] ? ACC_W'(diff_q) : '0);
      w_d   = w_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amb_q  <= amb_d;
    diff_q <= diff_d;
    w_q    <= w_d;
    acc_q  <= acc_d;
  end

  assign sum    = $signed({2'b00, amb_q, {sbt_pkg::WFRAC{1'b0}}}) + acc_q;
  assign prod_o = sum[sbt_pkg::PROD_W-1:0];
  assign done_o = done_q;

endmodule

/* design/sbt_div.sv */
// Restoring divider that yields one quotient bit per cycle.
module sbt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sbt_pkg::NUM_W-1:0]     num_i,
  input  logic [sbt_pkg::SAMPLE_W-1:0]  den_i,
  output logic                          done_o,
  output logic [sbt_pkg::OUT_W-1:0]     quo_o
);

  localparam int RW    = sbt_pkg::SAMPLE_W;
  localparam int QW    = sbt_pkg::OUT_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [RW-1:0]    den_q, den_d;
  logic [QW-1:0]    lo_q, lo_d;
  logic [RW+1:0]    trial;

  assign trial = {1'b0, rem_q, lo_q[QW-1]} - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    lo_d   = lo_q;
    if (start_i) begin
      rem_d  = num_i[sbt_pkg::NUM_W-1:QW];
      lo_d   = num_i[QW-1:0];
      den_d  = den_i;
      cnt_d  = CNT_W'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[RW+1]) begin
        rem_d = trial[RW-1:0];
        lo_d  = {lo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[RW-2:0], lo_q[QW-1]};
        lo_d  = {lo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    lo_q  <= lo_d;
  end

  assign quo_o  = lo_q;
  assign done_o = done_q;

endmodule

/* design/shadow_brightness_tracker_core.sv */
// Top level of the shadow brightness tracker with per-channel baselines.
// A sample item runs the 17-step serial blend multiplier, then the 8-step divider when
// the new local baseline is above the sample, and then gives a valid result beat; when
// the baseline is not above the sample the division is skipped and the result is zero.
// One item is in work at a time, so a sample item holds the input until its result is
// loaded, including any result stall, and a calibrate item is taken while idle.
// Reset clears both baselines of every channel and restores the default weights.
module shadow_brightness_tracker_core #(
  parameter int CHANNELS  = sbt_pkg::CHANNELS_DEF,
  parameter int FRAC_BITS = sbt_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sbt_in_if.sink                          in_i,
  sbt_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [sbt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sbt_pkg::WEIGHT_W-1:0]    cfg_data_i
);

  localparam int LOC_W    = sbt_pkg::SAMPLE_W + FRAC_BITS;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  sbt_pkg::state_e state_q, state_d;

  logic [sbt_pkg::WEIGHT_W-1:0] fast_q, fast_d;
  logic [sbt_pkg::WEIGHT_W-1:0] slow_q, slow_d;
  logic [sbt_pkg::SAMPLE_W-1:0] amb_q [CHANNELS];
  logic [LOC_W-1:0]             loc_q [CHANNELS];

  logic [CH_IDX_W-1:0]          idx_q;
  logic [sbt_pkg::CH_W-1:0]     ch_q;
  logic [sbt_pkg::SAMPLE_W-1:0] smp_q;
  logic [sbt_pkg::SAMPLE_W-1:0] whole_q;
  logic [sbt_pkg::OUT_W-1:0]    res_q;
  logic                         out_vld_q;
  logic [sbt_pkg::OUT_W-1:0]    out_bri_q;
  logic [sbt_pkg::CH_W-1:0]     out_ch_q;

  logic                         in_acc;
  logic                         ch_ok;
  logic [CH_IDX_W-1:0]          in_idx;
  logic [LOC_W-1:0]             smp_ext;
  logic [sbt_pkg::WEIGHT_W-1:0] w_sel;
  logic [sbt_pkg::WEIGHT_W-1:0] w_clamp;
  logic                         mul_start;
  logic                         mul_done;
  logic [sbt_pkg::PROD_W-1:0]   prod;
  logic [LOC_W-1:0]             nl;
  logic                         div_start;
  logic                         div_done;
  logic [sbt_pkg::OUT_W-1:0]    quo;
  logic [sbt_pkg::SAMPLE_W-1:0] delta;
  logic [sbt_pkg::NUM_W-1:0]    num;
  logic                         out_load;

  assign in_acc  = in_i.valid && in_i.ready;
  assign ch_ok   = 32'(in_i.channel) < CHANNELS;
  assign in_idx  = CH_IDX_W'(in_i.channel);
  assign smp_ext = {in_i.sample, {FRAC_BITS{1'b0}}};
  assign w_sel   = (smp_ext > loc_q[in_idx]) ? fast_q : slow_q;
  assign w_clamp = w_sel[sbt_pkg::WEIGHT_W-1] ? sbt_pkg::WEIGHT_ONE : w_sel;

  assign nl    = LOC_W'({prod, {FRAC_BITS{1'b0}}} >> sbt_pkg::WFRAC);
  assign delta = whole_q - smp_q;
  assign num   = {delta, {sbt_pkg::OUT_W{1'b0}}} - sbt_pkg::NUM_W'(delta);

  always_comb begin
    in_i.ready = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      sbt_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        mul_start  = in_i.valid && ch_ok && (in_i.op == sbt_pkg::OP_SAMPLE);
      end
      sbt_pkg::ST_PREP: begin
        div_start = whole_q > smp_q;
      end
      sbt_pkg::ST_OUT: begin
        out_load = !out_vld_q || out_o.ready;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sbt_pkg::ST_IDLE: if (mul_start) state_d = sbt_pkg::ST_MUL;
      sbt_pkg::ST_MUL:  if (mul_done) state_d = sbt_pkg::ST_PREP;
      sbt_pkg::ST_PREP: state_d = div_start ? sbt_pkg::ST_DIV : sbt_pkg::ST_OUT;
      sbt_pkg::ST_DIV:  if (div_done) state_d = sbt_pkg::ST_OUT;
      sbt_pkg::ST_OUT:  if (out_load) state_d = sbt_pkg::ST_IDLE;
      default:          state_d = sbt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fast_d = fast_q;
    slow_d = slow_q;
    if (cfg_we_i) begin
      case (sbt_pkg::cfg_reg_e'(cfg_idx_i))
        sbt_pkg::CFG_FAST: fast_d = cfg_data_i;
        sbt_pkg::CFG_SLOW: slow_d = cfg_data_i;
        default: begin
          fast_d = fast_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sbt_pkg::ST_IDLE;
      fast_q    <= sbt_pkg::FAST_RESET;
      slow_q    <= sbt_pkg::SLOW_RESET;
      out_vld_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        amb_q[i] <= '0;
        loc_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      fast_q    <= fast_d;
      slow_q    <= slow_d;
      out_vld_q <= out_load || (out_vld_q && !out_o.ready);
      if (in_acc && ch_ok && (in_i.op == sbt_pkg::OP_CAL)) begin
        amb_q[in_idx] <= in_i.sample;
        loc_q[in_idx] <= smp_ext;
      end
      if (mul_done) begin
        loc_q[idx_q] <= nl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      idx_q <= in_idx;
      ch_q  <= in_i.channel;
      smp_q <= in_i.sample;
    end
    if (mul_done) begin
      whole_q <= nl[LOC_W-1:FRAC_BITS];
    end
    if ((state_q == sbt_pkg::ST_PREP) && !div_start) begin
      res_q <= '0;
    end else if (div_done) begin
      res_q <= quo;
    end
    if (out_load) begin
      out_bri_q <= res_q;
      out_ch_q  <= ch_q;
    end
  end

  sbt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .amb_i   (amb_q[in_idx]),
    .smp_i   (in_i.sample),
    .w_i     (w_clamp),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  sbt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (whole_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign out_o.valid       = out_vld_q;
  assign out_o.brightness  = out_bri_q;
  assign out_o.out_channel = out_ch_q;

`include "shadow_brightness_tracker_core_macros.svh"

  `SBT_ASSERT_NEVER(a_mul_done_state, mul_done && (state_q != sbt_pkg::ST_MUL), "blend done outside multiply state")
  `SBT_ASSERT_NEVER(a_div_done_state, div_done && (state_q != sbt_pkg::ST_DIV), "quotient done outside divide state")
  `SBT_ASSERT(a_sample_starts_mul, (in_acc && ch_ok && (in_i.op == sbt_pkg::OP_SAMPLE)) |=> (state_q == sbt_pkg::ST_MUL), "accepted sample did not start the blend")

endmodule
